### rtl/bml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pkg
// Shared constants and types of the border median level unit.
// ----------------------------------------------------------------------------
package bml_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LEVELS     = 256;

    localparam int LEVEL_W   = 8;
    localparam int BIN_W     = 15;
    localparam int CFG_W     = 13;
    localparam int POS_W     = 12;
    localparam int LIMIT_W   = 14;
    localparam int SUM_W     = 23;   // holds LEVELS * BIN_MAX
    localparam int AMT_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // bin update broadcast to every cell
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [AMT_W-1:0]   amount;
    } t_upd;

    // search wavefront handed from cell to cell
    typedef struct packed {
        logic               tok;
        logic               found;
        logic [LEVEL_W-1:0] level;
        logic [SUM_W-1:0]   sum;
    } t_wave;

    // position tracker status
    typedef struct packed {
        logic             is_last;
        logic [AMT_W-1:0] amount;
    } t_pos;

endpackage
`default_nettype wire

### rtl/bml_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pixel_if / bml_median_if
// Valid/ready channels for incoming pixels and outgoing median levels.
// ----------------------------------------------------------------------------
interface bml_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_level;

    modport source (output valid, output pixel_level, input ready);
    modport sink   (input valid, input pixel_level, output ready);
endinterface

interface bml_median_if;
    logic       valid;
    logic       ready;
    logic [7:0] median_level;

    modport source (output valid, output median_level, input ready);
    modport sink   (input valid, input median_level, output ready);
endinterface
`default_nettype wire

### rtl/bml_pos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pos
// Raster position tracker: border weight of the current pixel, frame end
// flag and median threshold from the configured sizes.
// ----------------------------------------------------------------------------
module bml_pos
    import bml_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CFG_W-1:0]   i_width,
    input  wire logic [CFG_W-1:0]   i_height,
    input  wire logic               i_step,
    output t_pos                    o_pos,
    output logic [LIMIT_W-1:0]      o_limit
);

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [CFG_W-1:0] w_c, h_c, w_m1, h_m1;
    logic             first_col, first_row, last_col, last_row;

    always_comb begin
        if (i_width == '0)
            w_c = CFG_W'(1);
        else if (i_width > CFG_W'(MAX_WIDTH))
            w_c = CFG_W'(MAX_WIDTH);
        else
            w_c = i_width;

        if (i_height == '0)
            h_c = CFG_W'(1);
        else if (i_height > CFG_W'(MAX_HEIGHT))
            h_c = CFG_W'(MAX_HEIGHT);
        else
            h_c = i_height;

        w_m1 = w_c - CFG_W'(1);
        h_m1 = h_c - CFG_W'(1);

        // sizes may shrink mid-frame: at or beyond the edge counts as the edge
        last_col  = {1'b0, r_col} >= w_m1;
        last_row  = {1'b0, r_row} >= h_m1;
        first_col = r_col == '0;
        first_row = r_row == '0;

        o_pos.is_last = last_col && last_row;
        if (first_row || last_row)
            o_pos.amount = AMT_W'(1);
        else if (first_col || last_col)
            o_pos.amount = (w_c == CFG_W'(1)) ? AMT_W'(2) : AMT_W'(1);
        else
            o_pos.amount = '0;

        o_limit = LIMIT_W'(w_c) + LIMIT_W'(h_c) - LIMIT_W'(2);

        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (last_col && last_row) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + POS_W'(1);
            end else begin
                n_col = r_col + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

### rtl/bml_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_cell
// One histogram bin. Counts matching border pixels, then adds itself to the
// passing search wavefront and clears for the next frame.
// ----------------------------------------------------------------------------
module bml_cell
    import bml_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [LEVEL_W-1:0] i_index,
    input  wire t_upd               i_upd,
    input  wire logic [LIMIT_W-1:0] i_limit,
    input  wire t_wave              i_wave,
    output t_wave                   o_wave
);

    logic [BIN_W-1:0] r_bin, n_bin;
    t_wave            r_wave, n_wave;
    logic [BIN_W:0]   bin_sum;
    logic [SUM_W-1:0] run_sum;

    always_comb begin
        bin_sum = {1'b0, r_bin} + (BIN_W+1)'(i_upd.amount);
        n_bin   = r_bin;
        if (i_wave.tok)
            n_bin = '0;
        else if (i_upd.valid && i_upd.level == i_index)
            n_bin = bin_sum[BIN_W] ? BIN_MAX : bin_sum[BIN_W-1:0];

        run_sum      = i_wave.sum + SUM_W'(r_bin);
        n_wave       = i_wave;
        n_wave.sum   = run_sum;
        if (!i_wave.found && run_sum >= SUM_W'(i_limit)) begin
            n_wave.found = 1'b1;
            n_wave.level = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_wave <= '0;
        end else begin
            r_bin  <= n_bin;
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule
`default_nettype wire

### rtl/border_median_level_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per cycle within a frame; the frame's last pixel
// waits while an older result is still pending. After it transfers, the
// wavefront walks the 256-cell bin chain one cell a cycle; pixel input
// stalls until it leaves the last cell, where the result is registered.
// Reset (synchronous, active low): bins, position and output valid cleared,
// width 640, height 480.
// ----------------------------------------------------------------------------
// border_median_level_unit
// Border histogram of a raster gray frame and its lower median level.
// ----------------------------------------------------------------------------
module border_median_level_unit
    import bml_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    bml_pixel_if.sink                 i_pix,
    bml_median_if.source              o_med,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_width, r_height;
    logic               r_searching, r_inject;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    t_pos               pos;
    logic [LIMIT_W-1:0] limit;
    logic               pix_xfer, med_xfer;
    t_upd               upd;
    t_wave              wave [0:LEVELS];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold off pixels during a search, and the frame's last pixel while an older result still waits
    assign i_pix.ready = !r_searching && !(r_out_valid && pos.is_last);
    assign pix_xfer    = i_pix.valid && i_pix.ready;
    assign med_xfer    = r_out_valid && o_med.ready;

    bml_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_step   (pix_xfer),
        .o_pos    (pos),
        .o_limit  (limit)
    );

    assign upd.valid  = pix_xfer;
    assign upd.level  = i_pix.pixel_level;
    assign upd.amount = pos.amount;

    assign wave[0].tok   = r_inject;
    assign wave[0].found = 1'b0;
    assign wave[0].level = '0;
    assign wave[0].sum   = '0;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        bml_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (LEVEL_W'(g)),
            .i_upd   (upd),
            .i_limit (limit),
            .i_wave  (wave[g]),
            .o_wave  (wave[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inject    <= 1'b0;
            r_searching <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject <= pix_xfer && pos.is_last;
            if (pix_xfer && pos.is_last)
                r_searching <= 1'b1;
            else if (wave[LEVELS].tok)
                r_searching <= 1'b0;

            if (wave[LEVELS].tok)
                r_out_valid <= 1'b1;
            else if (med_xfer)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wave[LEVELS].tok)
            r_out_level <= wave[LEVELS].found ? wave[LEVELS].level : LEVEL_W'(LEVELS - 1);
    end

    assign o_med.valid        = r_out_valid;
    assign o_med.median_level = r_out_level;

`ifndef SYNTHESIS
    a_no_pixel_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_searching |-> !pix_xfer)
        else $error("pixel transfer during median search");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_xfer && pos.is_last) |=> (r_searching && r_inject))
        else $error("frame end did not start median search");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wave[LEVELS].tok |-> (!r_out_valid && r_searching))
        else $error("median result would overwrite a pending result");
`endif

endmodule
`default_nettype wire
